@@ rtl/kpg_pkg.sv @@
// ----------------------------------------------------------------------------
// kpg_pkg
// Shared types and constants for the Kronecker product gradient block.
// ----------------------------------------------------------------------------
package kpg_pkg;

    localparam int MAX_LEN_DEF   = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int LEN_W  = 6;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int PROD_W = 64;

    typedef enum logic [1:0] {
        FN_LOAD_A  = 2'd0,
        FN_LOAD_B  = 2'd1,
        FN_LOAD_G  = 2'd2,
        FN_COMPUTE = 2'd3
    } func_t;

    typedef enum logic {
        REG_LENGTH_A = 1'b0,
        REG_LENGTH_B = 1'b1
    } reg_idx_t;

    // tag that travels with each multiply-accumulate term
    typedef struct packed {
        logic             first;
        logic             fin;
        logic             which;
        logic [POS_W-1:0] pos;
        logic             last;
    } tag_t;

endpackage

@@ rtl/kpg_mem.sv @@
// ----------------------------------------------------------------------------
// kpg_mem
// Storage for vectors a, b and the flattened output gradient G.
// ----------------------------------------------------------------------------
module kpg_mem #(
    parameter int MAX_LEN = kpg_pkg::MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int GW = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [1:0]                  wr_func,
    input  logic [kpg_pkg::IDX_W-1:0]   wr_index,
    input  logic [kpg_pkg::DATA_W-1:0]  wr_data,
    input  logic [AW-1:0]               rd_a_addr,
    input  logic [AW-1:0]               rd_b_addr,
    input  logic [GW-1:0]               rd_g_addr,
    output logic [kpg_pkg::DATA_W-1:0]  rd_a_data,
    output logic [kpg_pkg::DATA_W-1:0]  rd_b_data,
    output logic [kpg_pkg::DATA_W-1:0]  rd_g_data
);

    localparam int VEC_DEPTH  = MAX_LEN;
    localparam int GRAD_DEPTH = MAX_LEN * MAX_LEN;

    logic [kpg_pkg::DATA_W-1:0] mem_a [VEC_DEPTH];
    logic [kpg_pkg::DATA_W-1:0] mem_b [VEC_DEPTH];
    logic [kpg_pkg::DATA_W-1:0] mem_g [GRAD_DEPTH];

    logic vec_in_range;
    logic grad_in_range;
    logic we_a;
    logic we_b;
    logic we_g;

    assign vec_in_range  = {1'b0, wr_index} < (kpg_pkg::IDX_W + 1)'(VEC_DEPTH);
    assign grad_in_range = {1'b0, wr_index} < (kpg_pkg::IDX_W + 1)'(GRAD_DEPTH);

    assign we_a = wr_en && (wr_func == kpg_pkg::FN_LOAD_A) && vec_in_range;
    assign we_b = wr_en && (wr_func == kpg_pkg::FN_LOAD_B) && vec_in_range;
    assign we_g = wr_en && (wr_func == kpg_pkg::FN_LOAD_G) && grad_in_range;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_index[AW-1:0]] <= wr_data;
        end
        rd_a_data <= mem_a[rd_a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[wr_index[AW-1:0]] <= wr_data;
        end
        rd_b_data <= mem_b[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_g)
        begin
            mem_g[wr_index[GW-1:0]] <= wr_data;
        end
        rd_g_data <= mem_g[rd_g_addr];
    end

endmodule

@@ rtl/kpg_seq.sv @@
// ----------------------------------------------------------------------------
// kpg_seq
// Sequencer: walks grad_a rows, then grad_b columns, one term per cycle.
// ----------------------------------------------------------------------------
module kpg_seq #(
    parameter int MAX_LEN = kpg_pkg::MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int GW = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [kpg_pkg::LEN_W-1:0]  len_a,
    input  logic [kpg_pkg::LEN_W-1:0]  len_b,
    input  logic                       final_out,
    output logic                       busy,
    output logic                       issue_valid,
    output kpg_pkg::tag_t              issue_tag,
    output logic [AW-1:0]              a_addr,
    output logic [AW-1:0]              b_addr,
    output logic [GW-1:0]              g_addr
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROWS  = 4'b0010,
        S_COLS  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [kpg_pkg::LEN_W-1:0] i_reg, i_next;
    logic [kpg_pkg::LEN_W-1:0] j_reg, j_next;
    logic [GW-1:0]             flat_reg, flat_next;

    logic i_end;
    logic j_end;

    assign i_end = (i_reg == len_a - kpg_pkg::LEN_W'(1));
    assign j_end = (j_reg == len_b - kpg_pkg::LEN_W'(1));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        flat_next  = flat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_ROWS;
                    i_next     = '0;
                    j_next     = '0;
                    flat_next  = '0;
                end
            end
            S_ROWS:
            begin
                if (j_end)
                begin
                    j_next = '0;
                    if (i_end)
                    begin
                        state_next = S_COLS;
                        i_next     = '0;
                        flat_next  = '0;
                    end
                    else
                    begin
                        i_next    = i_reg + kpg_pkg::LEN_W'(1);
                        flat_next = flat_reg + GW'(1);
                    end
                end
                else
                begin
                    j_next    = j_reg + kpg_pkg::LEN_W'(1);
                    flat_next = flat_reg + GW'(1);
                end
            end
            S_COLS:
            begin
                if (i_end)
                begin
                    i_next = '0;
                    if (j_end)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        j_next    = j_reg + kpg_pkg::LEN_W'(1);
                        flat_next = GW'(j_reg + kpg_pkg::LEN_W'(1));
                    end
                end
                else
                begin
                    i_next    = i_reg + kpg_pkg::LEN_W'(1);
                    flat_next = flat_reg + GW'(len_b);
                end
            end
            S_DRAIN:
            begin
                if (final_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            flat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            flat_reg  <= flat_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign issue_valid = (state_reg == S_ROWS) || (state_reg == S_COLS);
    assign a_addr      = i_reg[AW-1:0];
    assign b_addr      = j_reg[AW-1:0];
    assign g_addr      = flat_reg;

    always_comb
    begin
        if (state_reg == S_COLS)
        begin
            issue_tag.first = (i_reg == '0);
            issue_tag.fin   = i_end;
            issue_tag.which = 1'b1;
            issue_tag.pos   = j_reg[kpg_pkg::POS_W-1:0];
            issue_tag.last  = i_end && j_end;
        end
        else
        begin
            issue_tag.first = (j_reg == '0);
            issue_tag.fin   = j_end;
            issue_tag.which = 1'b0;
            issue_tag.pos   = i_reg[kpg_pkg::POS_W-1:0];
            issue_tag.last  = 1'b0;
        end
    end

endmodule

@@ rtl/kpg_mac.sv @@
// ----------------------------------------------------------------------------
// kpg_mac
// Shared multiply-accumulate unit with shift and saturation on each sum.
// ----------------------------------------------------------------------------
module kpg_mac #(
    parameter int MAX_LEN   = kpg_pkg::MAX_LEN_DEF,
    parameter int FRAC_BITS = kpg_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              issue_valid,
    input  kpg_pkg::tag_t                     issue_tag,
    input  logic signed [kpg_pkg::DATA_W-1:0] a_data,
    input  logic signed [kpg_pkg::DATA_W-1:0] b_data,
    input  logic signed [kpg_pkg::DATA_W-1:0] g_data,
    output logic                              strobe,
    output logic                              which,
    output logic [kpg_pkg::POS_W-1:0]         position,
    output logic signed [kpg_pkg::DATA_W-1:0] grad_value,
    output logic                              last
);

    localparam int ACC_W = kpg_pkg::PROD_W + $clog2(MAX_LEN) + 1;
    localparam int HI_W  = ACC_W - kpg_pkg::DATA_W + 1;

    logic                               v1_reg, v2_reg, v3_reg, strobe_reg;
    kpg_pkg::tag_t                      t1_reg, t2_reg, t3_reg;
    logic signed [kpg_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]            acc_reg, acc_next;
    logic signed [kpg_pkg::DATA_W-1:0]  operand;
    logic signed [ACC_W-1:0]            shifted;
    logic [HI_W-1:0]                    upper;
    logic signed [kpg_pkg::DATA_W-1:0]  sat_value;
    logic                               which_reg, last_reg;
    logic [kpg_pkg::POS_W-1:0]          pos_reg;
    logic signed [kpg_pkg::DATA_W-1:0]  value_reg;

    assign operand  = t1_reg.which ? a_data : b_data;
    assign acc_next = (t2_reg.first ? '0 : acc_reg)
                      + {{(ACC_W - kpg_pkg::PROD_W){prod_reg[kpg_pkg::PROD_W-1]}}, prod_reg};

    assign shifted = acc_reg >>> FRAC_BITS;
    assign upper   = shifted[ACC_W-1:kpg_pkg::DATA_W-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
        begin
            sat_value = shifted[kpg_pkg::DATA_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            sat_value = {1'b1, {(kpg_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(kpg_pkg::DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            strobe_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            v1_reg     <= issue_valid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg && t2_reg.fin;
            strobe_reg <= v3_reg;
            if (v2_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= issue_tag;
        t2_reg   <= t1_reg;
        t3_reg   <= t2_reg;
        prod_reg <= g_data * operand;
        if (v3_reg)
        begin
            which_reg <= t3_reg.which;
            pos_reg   <= t3_reg.pos;
            last_reg  <= t3_reg.last;
            value_reg <= sat_value;
        end
    end

    assign strobe     = strobe_reg;
    assign which      = which_reg;
    assign position   = pos_reg;
    assign grad_value = value_reg;
    assign last       = last_reg;

endmodule

@@ rtl/kronecker_product_gradient.sv @@
// ----------------------------------------------------------------------------
// kronecker_product_gradient
// Backward pass of the 1D Kronecker product c = a (x) b in signed Q16.16.
// ----------------------------------------------------------------------------
// A load item (a, b or flattened G element) is written to memory and busy stays
// low. A compute item holds busy high until its final result: one shared
// 32x32 multiplier and accumulator take one term per cycle, la*lb terms for
// grad_a and as many for grad_b, through read, multiply, add and saturate registers.
// Results come out on strobe for one cycle each, grad_a first, and cannot be
// stalled; last marks the final grad_b element.
// ----------------------------------------------------------------------------
module kronecker_product_gradient #(
    parameter int MAX_LEN   = kpg_pkg::MAX_LEN_DEF,
    parameter int FRAC_BITS = kpg_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        func,
    input  logic [kpg_pkg::IDX_W-1:0]         index,
    input  logic signed [kpg_pkg::DATA_W-1:0] value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [kpg_pkg::LEN_W-1:0]         cfg_data,
    output logic                              strobe,
    output logic                              which,
    output logic [kpg_pkg::POS_W-1:0]         position,
    output logic signed [kpg_pkg::DATA_W-1:0] grad_value,
    output logic                              last
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int GW = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1;

    logic [kpg_pkg::LEN_W-1:0] length_a_reg, length_b_reg;
    logic [kpg_pkg::LEN_W-1:0] len_a, len_b;
    logic                      accept;
    logic                      go;
    logic                      issue_valid;
    kpg_pkg::tag_t             issue_tag;
    logic [AW-1:0]             a_addr, b_addr;
    logic [GW-1:0]             g_addr;
    logic [kpg_pkg::DATA_W-1:0] a_data, b_data, g_data;

    function automatic logic [kpg_pkg::LEN_W-1:0] eff_len(
        input logic [kpg_pkg::LEN_W-1:0] r
    );
        logic [kpg_pkg::LEN_W-1:0] res;
        if (r == '0)
        begin
            res = kpg_pkg::LEN_W'(1);
        end
        else if ({1'b0, r} > (kpg_pkg::LEN_W + 1)'(MAX_LEN))
        begin
            res = kpg_pkg::LEN_W'(MAX_LEN);
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_a_reg <= kpg_pkg::LEN_W'(1);
            length_b_reg <= kpg_pkg::LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kpg_pkg::REG_LENGTH_A: length_a_reg <= cfg_data;
                kpg_pkg::REG_LENGTH_B: length_b_reg <= cfg_data;
                default:               length_a_reg <= length_a_reg;
            endcase
        end
    end

    assign len_a  = eff_len(length_a_reg);
    assign len_b  = eff_len(length_b_reg);
    assign accept = start && !busy;
    assign go     = accept && (func == kpg_pkg::FN_COMPUTE);

    kpg_mem #(
        .MAX_LEN (MAX_LEN)
    ) u_mem (
        .clk       (clk),
        .wr_en     (accept),
        .wr_func   (func),
        .wr_index  (index),
        .wr_data   (value),
        .rd_a_addr (a_addr),
        .rd_b_addr (b_addr),
        .rd_g_addr (g_addr),
        .rd_a_data (a_data),
        .rd_b_data (b_data),
        .rd_g_data (g_data)
    );

    kpg_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .len_a       (len_a),
        .len_b       (len_b),
        .final_out   (strobe && last),
        .busy        (busy),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .a_addr      (a_addr),
        .b_addr      (b_addr),
        .g_addr      (g_addr)
    );

    kpg_mac #(
        .MAX_LEN   (MAX_LEN),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .a_data      (a_data),
        .b_data      (b_data),
        .g_data      (g_data),
        .strobe      (strobe),
        .which       (which),
        .position    (position),
        .grad_value  (grad_value),
        .last        (last)
    );

    a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe outside a compute run");

    a_last_is_grad_b: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> which)
        else $error("last result is not a grad_b element");

    a_compute_holds: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("compute item did not raise busy");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("busy still high after final result");

endmodule
